@@ hdl/arp_cache_table_macros.svh @@
// assertion macros for the arp cache table
// no dependencies; included by the top level, which supplies clk and rst_n
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARPC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ARPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/arpc_pkg.sv @@
// shared types, opcodes and helpers for the arp cache table
// no dependencies; used by arpc_cell and arp_cache_table
package arpc_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int SLOT_W       = 8;
  localparam int IP_W         = 32;
  localparam int MAC_W        = 48;
  localparam int TIME_W       = 32;
  localparam int TIMEOUT_W    = 16;
  localparam int LFSR_W       = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;
  localparam logic [LFSR_W-1:0]    LFSR_SEED   = 16'hACE1;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // search token passed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [MAC_W-1:0]  mac;
    logic              inv;
    logic [SLOT_W-1:0] inv_idx;
  } arpc_tok_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              wr_en;
    logic              tick_en;
    logic [SLOT_W-1:0] wr_idx;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
  } arpc_cmd_t;

  // fibonacci lfsr, taps 16 14 13 11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

@@ hdl/arpc_cell.sv @@
// one table entry: valid bit, ip, mac, insert time, plus one search stage
// depends on arpc_pkg
module arpc_cell
  import arpc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arpc_cmd_t            cmd,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  arpc_tok_t            tok_i,
  output arpc_tok_t            tok_o
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  logic              valid_r;
  logic              valid_nxt;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TIME_W-1:0] added_r;
  logic [TIME_W-1:0] age;
  logic              wr_hit;
  logic              match;
  arpc_tok_t         tok_nxt;
  arpc_tok_t         tok_r;

  assign wr_hit = cmd.wr_en && (cmd.wr_idx == MY_IDX);
  assign age    = cmd.now - added_r;
  assign match  = valid_r && (ip_r == cmd.ip);

  always_comb begin
    valid_nxt = valid_r;
    if (wr_hit) begin
      valid_nxt = 1'b1;
    end else if (cmd.tick_en && valid_r && (age > TIME_W'(timeout))) begin
      valid_nxt = 1'b0;
    end
  end

  // first valid match wins, last invalid slot wins
  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.found && match) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = MY_IDX;
      tok_nxt.mac   = mac_r;
    end
    if (!valid_r) begin
      tok_nxt.inv     = 1'b1;
      tok_nxt.inv_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      ip_r    <= cmd.ip;
      mac_r   <= cmd.mac;
      added_r <= cmd.now;
    end
    tok_r <= tok_nxt;
  end

  assign tok_o = tok_r;

endmodule

@@ hdl/arp_cache_table.sv @@
// arp cache table: lookup and insert run a search state, counted out by cnt_r, and then
// a done state, from which out_valid is registered; the search token walks the chain of
// ENTRIES cells one per cycle; victim quotient then remainder are registered in search
// tick and unused ops run the exec state, then strobe out_valid; out_valid cannot stall
// synchronous active-low reset clears all valid bits, time to zero, lfsr to 0xace1
`include "arp_cache_table_macros.svh"
module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [IP_W-1:0]      in_ip_addr,
  input  logic [MAC_W-1:0]     in_mac_in,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [MAC_W-1:0]     out_mac_out,
  output logic [SLOT_W-1:0]    out_slot,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IW      = $clog2(ENTRIES);
  localparam int SRCH_N  = ENTRIES;
  localparam int CW      = $clog2(SRCH_N);
  localparam int QSH     = LFSR_W + IW;
  // ceil(2^QSH / ENTRIES) gives an exact quotient for every 16-bit victim value
  localparam logic [63:0] RCP_L = ((64'd1 << QSH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [LFSR_W:0] RCP = RCP_L[LFSR_W:0];

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_EXEC   = 2'd3;

  localparam logic REG_TIMEOUT = 1'b0;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r;
  logic [LFSR_W-1:0]    sh_r;
  logic [LFSR_W-1:0]    quo_r;
  logic [IW-1:0]        rem_r;
  logic [2*LFSR_W:0]    prod;
  logic [2*LFSR_W:0]    quo_w;
  logic [LFSR_W+SLOT_W:0] qe;
  logic [LFSR_W-1:0]    rem_w;
  logic [LFSR_W-1:0]    lfsr_r;
  logic [LFSR_W-1:0]    lfsr_nxt;
  logic [TIME_W-1:0]    now_r;
  logic [TIME_W-1:0]    now_inc;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [1:0]           q_op_r;
  logic [IP_W-1:0]      q_ip_r;
  logic [MAC_W-1:0]     q_mac_r;
  logic                 accept;
  logic                 cfg_wr;
  logic                 is_lookup;
  logic                 is_insert;
  logic [SLOT_W-1:0]    ins_slot;
  arpc_cmd_t            cmd;
  arpc_tok_t            tok [ENTRIES+1];
  arpc_tok_t            tail;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [MAC_W-1:0]     out_mac_r;
  logic [SLOT_W-1:0]    out_slot_r;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_r} : 32'd0;
  assign is_lookup = (q_op_r == OP_LOOKUP);
  assign is_insert = (q_op_r == OP_INSERT);
  assign now_inc   = now_r + 32'd1;
  assign lfsr_nxt  = lfsr_step(lfsr_r);
  assign tail      = tok[ENTRIES];

  // victim value mod ENTRIES: reciprocal multiply, then multiply back and subtract
  assign prod  = (2*LFSR_W+1)'(sh_r) * (2*LFSR_W+1)'(RCP);
  assign quo_w = prod >> QSH;
  assign qe    = (LFSR_W+SLOT_W+1)'(quo_r) * (LFSR_W+SLOT_W+1)'(ENTRIES);
  assign rem_w = sh_r - qe[LFSR_W-1:0];

  always_comb begin
    if (tail.found) begin
      ins_slot = tail.idx;
    end else if (tail.inv) begin
      ins_slot = tail.inv_idx;
    end else begin
      ins_slot = SLOT_W'(rem_r);
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.ip      = q_ip_r;
    cmd.mac     = q_mac_r;
    cmd.wr_idx  = ins_slot;
    cmd.now     = now_r;
    if (state_r == ST_DONE && is_insert) begin
      cmd.wr_en = 1'b1;
    end
    if (state_r == ST_EXEC && q_op_r == OP_TICK) begin
      cmd.tick_en = 1'b1;
      cmd.now     = now_inc;
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .timeout (timeout_r),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_LOOKUP || in_op == OP_INSERT) ? ST_SEARCH : ST_EXEC;
        end
      end
      ST_SEARCH: begin
        if (cnt_r == CW'(SRCH_N - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      lfsr_r      <= LFSR_SEED;
      now_r       <= '0;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE) || (state_r == ST_EXEC);
      if (cfg_wr && paddr[2] == REG_TIMEOUT) begin
        timeout_r <= pwdata[TIMEOUT_W-1:0];
      end
      if (accept) begin
        cnt_r <= '0;
        if (in_op == OP_INSERT) begin
          lfsr_r <= lfsr_nxt;
        end
      end else if (state_r == ST_SEARCH) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.tick_en) begin
        now_r <= now_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op_r  <= in_op;
      q_ip_r  <= in_ip_addr;
      q_mac_r <= in_mac_in;
      sh_r    <= lfsr_nxt;
    end else if (state_r == ST_SEARCH) begin
      quo_r <= quo_w[LFSR_W-1:0];
      rem_r <= rem_w[IW-1:0];
    end
    if (state_r == ST_DONE) begin
      out_hit_r  <= is_lookup && tail.found;
      out_mac_r  <= (is_lookup && tail.found) ? tail.mac : '0;
      if (is_lookup) begin
        out_slot_r <= tail.found ? tail.idx : '0;
      end else begin
        out_slot_r <= ins_slot;
      end
    end else if (state_r == ST_EXEC) begin
      out_hit_r  <= 1'b0;
      out_mac_r  <= '0;
      out_slot_r <= '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_mac_out = out_mac_r;
  assign out_slot    = out_slot_r;

  `ARPC_ASSERT_NEXT(a_strobe_after_done, state_r == ST_DONE, out_valid, "no strobe after search")
  `ARPC_ASSERT_NEXT(a_busy_after_accept, accept, busy, "accepted transaction not busy")
  `ARPC_ASSERT_NOW(a_hit_only_lookup, out_valid && !is_lookup, !out_hit, "hit on non-lookup")
  `ARPC_ASSERT_NEXT(a_insert_slot_range, state_r == ST_DONE && is_insert,
                    (SLOT_W+1)'(out_slot) < (SLOT_W+1)'(ENTRIES), "insert slot out of range")

endmodule

@@ dv/arp_cache_table_test.sv @@
// self-checking testbench for arp_cache_table: directed and random lookup, insert and tick traffic
// predicts every reply from its own table model; needs arpc_pkg and the arp_cache_table rtl
`timescale 1ns / 1ps

module arp_cache_table_test;
  import arpc_pkg::*;

  localparam int N_ENTRIES = ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_MAX = 64;

  typedef struct {
    logic              hit;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
  } arp_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_op = OP_LOOKUP;
  logic [IP_W-1:0] in_ip_addr = '0;
  logic [MAC_W-1:0] in_mac_in = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy;
  logic out_valid;
  logic out_hit;
  logic [MAC_W-1:0] out_mac_out;
  logic [SLOT_W-1:0] out_slot;
  logic [31:0] prdata;
  logic pready;

  // table model
  logic              tbl_valid [N_ENTRIES];
  logic [IP_W-1:0]   tbl_ip    [N_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac   [N_ENTRIES];
  logic [TIME_W-1:0] tbl_added [N_ENTRIES];
  logic [TIME_W-1:0] sec_count;
  logic [LFSR_W-1:0] victim_sr;
  logic [TIMEOUT_W-1:0] age_limit;

  arp_reply_t pending_replies[$];
  arp_reply_t want;
  logic [IP_W-1:0] ip_pool [POOL_MAX];
  int fail_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  arp_cache_table #(.ENTRIES(N_ENTRIES)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_ip_addr(in_ip_addr), .in_mac_in(in_mac_in),
    .out_valid(out_valid), .out_hit(out_hit), .out_mac_out(out_mac_out),
    .out_slot(out_slot),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d replies outstanding", $time, pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // every strobed reply is compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected reply: hit=%0d mac=%h slot=%0d", $time, out_hit,
                 out_mac_out, out_slot);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t hit: expected %0d, got %0d", $time, want.hit, out_hit);
          fail_count++;
        end
        if (out_mac_out !== want.mac) begin
          $display("%0t mac_out: expected %h, got %h", $time, want.mac, out_mac_out);
          fail_count++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t slot: expected %0d, got %0d", $time, want.slot, out_slot);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_table();
    for (int i = 0; i < N_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_added[i] = '0;
    end
    sec_count = '0;
    victim_sr = 16'hACE1;
    age_limit = 16'd15;
  endfunction

  // applies one transaction to the table model and returns the reply it should give
  function automatic arp_reply_t predict_arp_reply(logic [1:0] op, logic [IP_W-1:0] ip,
                                                   logic [MAC_W-1:0] mac);
    arp_reply_t r;
    int chosen;
    bit found;
    logic [TIME_W-1:0] age;
    r.hit = 1'b0;
    r.mac = '0;
    r.slot = '0;
    found = 1'b0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!found && tbl_valid[i] && tbl_ip[i] == ip) begin
            found = 1'b1;
            r.hit = 1'b1;
            r.mac = tbl_mac[i];
            r.slot = i[SLOT_W-1:0];
          end
        end
      end
      OP_INSERT: begin
        victim_sr = {victim_sr[0] ^ victim_sr[2] ^ victim_sr[3] ^ victim_sr[5],
                     victim_sr[LFSR_W-1:1]};
        chosen = int'(victim_sr) % N_ENTRIES;
        // existing mapping wins, else the last free slot, else the lfsr victim
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!found) begin
            if (!tbl_valid[i]) chosen = i;
            else if (tbl_ip[i] == ip) begin
              chosen = i;
              found = 1'b1;
            end
          end
        end
        tbl_valid[chosen] = 1'b1;
        tbl_ip[chosen] = ip;
        tbl_mac[chosen] = mac;
        tbl_added[chosen] = sec_count;
        r.slot = chosen[SLOT_W-1:0];
      end
      OP_TICK: begin
        sec_count = sec_count + 1;
        for (int i = 0; i < N_ENTRIES; i++) begin
          age = sec_count - tbl_added[i];
          if (tbl_valid[i] && age > {16'd0, age_limit}) tbl_valid[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    return {hi[15:0], lo};
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac);
    int gap;
    if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_ip_addr <= ip;
    in_mac_in <= mac;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_arp_reply(op, ip, mac));
  endtask

  // hold off new transactions until every reply is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0 || busy);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    age_limit = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_empty_lookup();
    send_item(OP_LOOKUP, 32'h0000_0000, '0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
  endtask

  task automatic test_insert_lookup();
    send_item(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000, 48'h0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    send_item(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    // same ip again must land on its old slot
    send_item(OP_INSERT, 32'hFFFF_FFFF, 48'h5A5A_A5A5_0F0F);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFE, '0);
  endtask

  task automatic test_unused_op();
    send_item(OP_UNUSED, 32'h0000_0000, '0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_TICK, $urandom, rand_mac());
  endtask

  task automatic test_aging();
    logic [IP_W-1:0] ip;
    ip = 32'hC0A8_0001;
    write_timeout(16'd1);
    send_item(OP_INSERT, ip, 48'h0011_2233_4455);
    send_item(OP_TICK, '0, '0);
    send_item(OP_LOOKUP, ip, '0);
    send_item(OP_TICK, '0, '0);
    // expired entry is no longer visible and its slot is free again
    send_item(OP_LOOKUP, ip, '0);
    send_item(OP_INSERT, ip, 48'h6677_8899_AABB);
    send_item(OP_LOOKUP, ip, '0);
  endtask

  task automatic test_random_phase(input logic [TIMEOUT_W-1:0] timeout, input int count,
                                   input int tick_pct, input int pool_size);
    int r;
    logic [IP_W-1:0] ip;
    write_timeout(timeout);
    for (int i = 0; i < pool_size; i++) begin
      ip_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      ip = ($urandom_range(0, 9) < 8) ? ip_pool[$urandom_range(0, pool_size - 1)] : $urandom;
      if (r < 3) send_item(OP_UNUSED, $urandom, rand_mac());
      else if (r < 3 + tick_pct) send_item(OP_TICK, $urandom, rand_mac());
      else if (r < 3 + tick_pct + (97 - tick_pct) / 2) send_item(OP_LOOKUP, ip, rand_mac());
      else send_item(OP_INSERT, ip, rand_mac());
    end
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lookup();
    test_insert_lookup();
    test_unused_op();
    test_aging();
    // long timeout and few ticks fill the table and force victim eviction
    test_random_phase(16'hFFFF, 500, 2, 48);
    test_random_phase(16'd3, 400, 25, 24);
    test_random_phase(16'd1, 300, 15, 40);
    test_random_phase(16'd20, 400, 10, 40);
    test_random_phase(16'($urandom_range(2, 12)), 300, 12, 64);
    drain();
    repeat (N_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/arpc_pkg.sv
hdl/arpc_cell.sv
hdl/arp_cache_table.sv
dv/arp_cache_table_test.sv
